// ===== sv/c128b_pkg.sv =====
// Shared types, constants and the symbol pattern table of the Code 128 B encoder.
package c128b_pkg;

  // Symbol values and checksum modulus
  localparam logic [6:0] SymStartB  = 7'd104;
  localparam logic [6:0] SymStop    = 7'd106;
  localparam logic [6:0] CheckMod   = 7'd103;
  localparam logic [6:0] CheckInit  = 7'd1;    // 104 mod 103
  localparam logic [6:0] WeightMax  = 7'd102;  // weight wraps to 0 after this
  localparam logic [6:0] ModWidthMin = 7'd2;
  localparam logic [6:0] ModWidthMax = 7'd64;
  localparam logic [6:0] CharLow    = 7'd32;

  // floor(2^16 / 103): quotient estimate is exact or one low for 14-bit products
  localparam logic [23:0] RecipMod  = 24'd636;

  // Pattern digits, one nibble each, first element in the top nibble.
  // Six-element symbols carry a zero in the lowest nibble; the last entry is STOP.
  localparam int unsigned NumPat = 107;
  localparam logic [27:0] PatTable [NumPat] = '{
    28'h2122220, 28'h2221220, 28'h2222210, 28'h1212230,
    28'h1213220, 28'h1312220, 28'h1222130, 28'h1223120,
    28'h1322120, 28'h2212130, 28'h2213120, 28'h2312120,
    28'h1122320, 28'h1221320, 28'h1222310, 28'h1132220,
    28'h1231220, 28'h1232210, 28'h2232110, 28'h2211320,
    28'h2212310, 28'h2132120, 28'h2231120, 28'h3121310,
    28'h3112220, 28'h3211220, 28'h3212210, 28'h3122120,
    28'h3221120, 28'h3222110, 28'h2121230, 28'h2123210,
    28'h2321210, 28'h1113230, 28'h1311230, 28'h1313210,
    28'h1123130, 28'h1321130, 28'h1323110, 28'h2113130,
    28'h2311130, 28'h2313110, 28'h1121330, 28'h1123310,
    28'h1321310, 28'h1131230, 28'h1133210, 28'h1331210,
    28'h3131210, 28'h2113310, 28'h2311310, 28'h2131130,
    28'h2133110, 28'h2131310, 28'h3111230, 28'h3113210,
    28'h3311210, 28'h3121130, 28'h3123110, 28'h3321110,
    28'h3141110, 28'h2214110, 28'h4311110, 28'h1112240,
    28'h1114220, 28'h1211240, 28'h1214210, 28'h1411220,
    28'h1412210, 28'h1122140, 28'h1124120, 28'h1221140,
    28'h1224110, 28'h1421120, 28'h1422110, 28'h2412110,
    28'h2211140, 28'h4131110, 28'h2411120, 28'h1341110,
    28'h1112420, 28'h1211420, 28'h1212410, 28'h1142120,
    28'h1241120, 28'h1242110, 28'h4112120, 28'h4211120,
    28'h4212110, 28'h2121410, 28'h2141210, 28'h4121210,
    28'h1111430, 28'h1113410, 28'h1311410, 28'h1141130,
    28'h1143110, 28'h4111130, 28'h4113110, 28'h1131410,
    28'h1141310, 28'h3111410, 28'h4111310, 28'h2114120,
    28'h2112140, 28'h2112320, 28'h2331112
  };

  // One message character waiting for encoding
  typedef struct packed {
    logic [6:0] val;
    logic       last;
  } job_t;

  // Sequencer requests to the checksum unit
  typedef struct packed {
    logic       restart;  // START B issued: set sum and weight to CheckInit
    logic       add;      // data symbol issued: add val times weight
    logic [6:0] val;
  } ck_ctrl_t;

  // One bar or space element
  typedef struct packed {
    logic [8:0] width;
    logic       is_bar;
    logic [6:0] sym;
    logic       eob;
    logic       lor;
  } elem_t;

endpackage

// ===== sv/c128b_check.sv =====
// Running Code 128 checksum: pipelined value-times-weight product and mod 103 reduction.
module c128b_check import c128b_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ck_ctrl_t   ctrl_i,
  output logic [6:0] sum_o
);

  logic [6:0]  weight_q, weight_d;
  logic [6:0]  acc_q, acc_d;
  logic        s1_q, s2_q, s3_q;
  logic [13:0] p_q, p2_q;
  logic [6:0]  q_q, r_q;
  logic [23:0] prod_est;
  logic [13:0] rem;
  logic [13:0] rem_fold;
  logic [7:0]  acc_sum;

  // Advance the position weight, wrapping mod 103
  always_comb begin
    weight_d = weight_q;
    if (ctrl_i.restart) begin
      weight_d = CheckInit;
    end else if (ctrl_i.add) begin
      weight_d = (weight_q == WeightMax) ? 7'd0 : weight_q + 7'd1;
    end
  end

  // Quotient estimate by reciprocal, then remainder with one correction
  assign prod_est = {10'd0, p_q} * RecipMod;
  assign rem      = p2_q - 14'({7'd0, q_q} * {7'd0, CheckMod});
  assign rem_fold = (rem >= {7'd0, CheckMod}) ? rem - {7'd0, CheckMod} : rem;

  // Fold the remainder into the running sum
  assign acc_sum = {1'b0, acc_q} + {1'b0, r_q};
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.restart) begin
      acc_d = CheckInit;
    end else if (s3_q) begin
      acc_d = (acc_sum >= {1'b0, CheckMod}) ? 7'(acc_sum - {1'b0, CheckMod}) : acc_sum[6:0];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= CheckInit;
      acc_q    <= CheckInit;
      s1_q     <= 1'b0;
      s2_q     <= 1'b0;
      s3_q     <= 1'b0;
    end else begin
      weight_q <= weight_d;
      acc_q    <= acc_d;
      s1_q     <= ctrl_i.add;
      s2_q     <= s1_q;
      s3_q     <= s2_q;
    end
  end

  // Pipeline data
  always_ff @(posedge clk_i) begin
    p_q  <= {7'd0, ctrl_i.val} * {7'd0, weight_q};
    p2_q <= p_q;
    q_q  <= prod_est[22:16];
    r_q  <= rem_fold[6:0];
  end

  assign sum_o = acc_q;

endmodule

// ===== sv/c128b_seq.sv =====
// Symbol sequencer: pattern ROM with registered read, element stepping and output register.
module c128b_seq import c128b_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [6:0] mw_i,
  input  logic       job_valid_i,
  input  job_t       job_i,
  output logic       job_pop_o,
  input  logic [6:0] ck_sum_i,
  output ck_ctrl_t   ck_ctrl_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output elem_t      elem_o
);

  // Symbol phase within one character
  localparam logic [1:0] PhHead  = 2'd0;  // START B if no message is open, else data
  localparam logic [1:0] PhData  = 2'd1;
  localparam logic [1:0] PhCheck = 2'd2;
  localparam logic [1:0] PhStop  = 2'd3;

  logic        act_q, act_d;
  job_t        act_job_q;
  logic [1:0]  phase_q, phase_d;
  logic        in_msg_q, in_msg_d;
  logic        cur_q, cur_d;
  logic [6:0]  sym_q;
  logic        stop_q, runlast_q;
  logic [2:0]  k_q, k_d;
  logic [27:0] pat_q;
  logic        ov_q, ov_d;
  elem_t       elem_q;

  logic        advance, fire, last_digit, slot_free, issue, load;
  logic [6:0]  iss_sym;
  logic        iss_stop, iss_runlast, iss_done;
  logic [1:0]  iss_next;
  logic [2:0]  nib_idx;
  logic [3:0]  nib;
  logic [9:0]  width_full;
  elem_t       elem_d;

  // Element stepping
  assign advance    = !ov_q || out_ready_i;
  assign fire       = cur_q && advance;
  assign last_digit = (k_q == (stop_q ? 3'd6 : 3'd5));
  assign slot_free  = !cur_q || (fire && last_digit);
  assign issue      = slot_free && act_q;

  // Decode the next symbol of the active character
  always_comb begin
    iss_sym     = act_job_q.val;
    iss_stop    = 1'b0;
    iss_runlast = 1'b0;
    iss_done    = 1'b0;
    iss_next    = phase_q;
    ck_ctrl_o   = '{restart: 1'b0, add: 1'b0, val: act_job_q.val};
    in_msg_d    = in_msg_q;
    unique case (phase_q)
      PhHead, PhData: begin
        if (phase_q == PhHead && !in_msg_q) begin
          iss_sym           = SymStartB;
          iss_next          = PhData;
          ck_ctrl_o.restart = issue;
          if (issue) begin
            in_msg_d = 1'b1;
          end
        end else begin
          iss_sym       = act_job_q.val;
          iss_runlast   = !act_job_q.last;
          iss_done      = !act_job_q.last;
          iss_next      = PhCheck;
          ck_ctrl_o.add = issue;
        end
      end
      PhCheck: begin
        iss_sym  = ck_sum_i;
        iss_next = PhStop;
      end
      PhStop: begin
        iss_sym     = SymStop;
        iss_stop    = 1'b1;
        iss_runlast = 1'b1;
        iss_done    = 1'b1;
        if (issue) begin
          in_msg_d = 1'b0;
        end
      end
      default: begin
        iss_sym = act_job_q.val;
      end
    endcase
  end

  // Take the next character when the slot empties or the current one finishes
  assign load      = job_valid_i && (!act_q || (issue && iss_done));
  assign job_pop_o = load;

  always_comb begin
    act_d   = act_q;
    phase_d = phase_q;
    if (load) begin
      act_d   = 1'b1;
      phase_d = PhHead;
    end else if (issue && iss_done) begin
      act_d = 1'b0;
    end else if (issue) begin
      phase_d = iss_next;
    end
  end

  // Current symbol: load on issue, step on fire, drop after its last element
  always_comb begin
    cur_d = cur_q;
    k_d   = k_q;
    if (issue) begin
      cur_d = 1'b1;
      k_d   = 3'd0;
    end else if (fire && last_digit) begin
      cur_d = 1'b0;
    end else if (fire) begin
      k_d = k_q + 3'd1;
    end
  end

  // Build the element from the pattern digit
  assign nib_idx    = 3'd6 - k_q;
  assign nib        = pat_q[{nib_idx, 2'b00} +: 4];
  assign width_full = {7'd0, nib[2:0]} * {3'd0, mw_i};
  always_comb begin
    elem_d.width  = width_full[8:0];
    elem_d.is_bar = !k_q[0];
    elem_d.sym    = sym_q;
    elem_d.eob    = stop_q && last_digit;
    elem_d.lor    = runlast_q && last_digit;
  end

  // Output register: fill on fire, drain when taken
  always_comb begin
    ov_d = ov_q;
    if (fire) begin
      ov_d = 1'b1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      phase_q  <= PhHead;
      in_msg_q <= 1'b0;
      cur_q    <= 1'b0;
      k_q      <= 3'd0;
      ov_q     <= 1'b0;
    end else begin
      act_q    <= act_d;
      phase_q  <= phase_d;
      in_msg_q <= in_msg_d;
      cur_q    <= cur_d;
      k_q      <= k_d;
      ov_q     <= ov_d;
    end
  end

  // Pattern ROM read and symbol payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      act_job_q <= job_i;
    end
    if (issue) begin
      pat_q      <= PatTable[iss_sym];
      sym_q      <= iss_sym;
      stop_q     <= iss_stop;
      runlast_q  <= iss_runlast;
    end
    if (fire) begin
      elem_q <= elem_d;
    end
  end

  assign out_valid_o = ov_q;
  assign elem_o      = elem_q;

endmodule

// ===== sv/code128b_symbol_encoder.sv =====
// Top level of the Code 128 subset B encoder: input buffer, module width register, units.
//
// Each accepted character yields its bar and space elements on the output stream, one
// element per cycle unless the output stalls: 6 for a character inside a message, 12
// for the first (START B ahead of it), 19 for the last (checksum and STOP after it) and
// 25 for a one-character message. The output channel sets this rate; the pattern ROM is
// read once per symbol, ahead of need, so symbols follow each other without a gap. A
// one-entry input buffer takes the next character while the current one is still being
// emitted, and the checksum pipeline finishes well before the checksum symbol
// is due. Module width writes saturate to 2..64 and must only happen while idle.
module code128b_symbol_encoder import c128b_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // module width register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  // characters in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // last_char
  // elements out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [8:0] element_width, [15:9] symbol_value
  output logic [1:0]  m_axis_tuser,   // [0] is_bar, [1] end_of_barcode
  output logic        m_axis_tlast    // last_of_run
);

  logic       buf_v_q, buf_v_d;
  job_t       buf_q;
  logic       job_pop;
  logic [6:0] mw_q;
  logic [6:0] cfg_sat;
  logic [6:0] ck_sum;
  ck_ctrl_t   ck_ctrl;
  elem_t      elem;
  logic       accept;
  logic [6:0] in_val;

  // Saturate the module width into range
  assign cfg_ready_o = 1'b1;
  assign cfg_sat = (cfg_data_i < ModWidthMin) ? ModWidthMin :
                   (cfg_data_i > ModWidthMax) ? ModWidthMax : cfg_data_i;

  // Map the byte to a symbol value; bytes outside 32..127 become space
  assign in_val = (!s_axis_tdata[7] && (s_axis_tdata[6:5] != 2'b00)) ?
                  s_axis_tdata[6:0] - CharLow : 7'd0;

  // Input buffer
  assign s_axis_tready = !buf_v_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  always_comb begin
    buf_v_d = buf_v_q;
    if (accept) begin
      buf_v_d = 1'b1;
    end else if (job_pop) begin
      buf_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_v_q <= 1'b0;
      mw_q    <= ModWidthMin;
    end else begin
      buf_v_q <= buf_v_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mw_q <= cfg_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_q <= '{val: in_val, last: s_axis_tlast};
    end
  end

  c128b_check u_check (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ck_ctrl),
    .sum_o  (ck_sum)
  );

  c128b_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mw_i        (mw_q),
    .job_valid_i (buf_v_q),
    .job_i       (buf_q),
    .job_pop_o   (job_pop),
    .ck_sum_i    (ck_sum),
    .ck_ctrl_o   (ck_ctrl),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .elem_o      (elem)
  );

  // Pack the element onto the stream
  assign m_axis_tdata = {elem.sym, elem.width};
  assign m_axis_tuser = {elem.eob, elem.is_bar};
  assign m_axis_tlast = elem.lor;

`ifndef NO_ASSERTIONS
  // Checksum stays reduced
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ck_sum < CheckMod) else $error("checksum out of range");

  // STOP end always closes the run of its character
  a_eob_lor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast) else $error("eob without tlast");

  // START and data symbols never issue together
  a_ck_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ck_ctrl.restart && ck_ctrl.add)) else $error("checksum restart and add collide");

  // Element width follows from digit 1..4 times width 2..64
  a_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[8:0] >= 9'd2 && m_axis_tdata[8:0] <= 9'd256))
    else $error("element width out of range");
`endif

endmodule
